// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// clocked property, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// clocked property, checked during reset too
`define ASSERT_CLK_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif

`endif

// ----- hw/rtl/sif_pkg.sv -----
// types and constants of the set intersection filter
`default_nettype none

package sif_pkg;

   localparam int ELEMENT_W = 10;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_PROBE = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE
   } sif_state_type;

   typedef struct packed {
      logic load_we;
      logic probe_rd;
      logic rep_we;
      logic out_load;
      logic clr_step;
   } sif_cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic needs_out;
      logic clr_done;
   } sif_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/set_intersection_filter.sv -----
// top level of the set intersection filter
//
// Requests arrive on req_valid/req_ready with req_mode, req_element and
// req_last. A load request (mode 0) marks its element present. A probe
// request (mode 1) has the membership stores read at the accepting edge and
// is decided in the decide state that follows, which sets the
// rsp_ registers. An element present and not yet reported gives one result
// with rsp_member set; the probe flagged last always gives a result with
// rsp_done_res set. Loads and other non-matching probes give no result.
// Results sit in an output register on rsp_valid/rsp_ready; loads are still
// taken while a result waits, and a probe that must report holds in its
// decide cycle until the waiting result is taken.
// After reset, and after each last probe, a clearing sweep of all DOMAIN_SIZE
// entries sets both stores to zero, one entry per cycle, with req_ready low.
// Elements at or above DOMAIN_SIZE never load and never match.
`default_nettype none

module set_intersection_filter
   import sif_pkg::*;
#(
   parameter int DOMAIN_SIZE = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_mode,
   input  wire logic [ELEMENT_W-1:0] req_element,
   input  wire logic                 req_last,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [ELEMENT_W-1:0]      rsp_value,
   output logic                      rsp_member,
   output logic                      rsp_done_res
);

   sif_cmd_type    cmd;
   sif_status_type status;

   sif_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sif_dpath #(
      .DOMAIN_SIZE (DOMAIN_SIZE)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_element  (req_element),
      .req_last     (req_last),
      .cmd          (cmd),
      .status       (status),
      .rsp_value    (rsp_value),
      .rsp_member   (rsp_member),
      .rsp_done_res (rsp_done_res)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/sif_ctrl.sv -----
// control state machine of the set intersection filter
`default_nettype none
`include "assert_macros.svh"

module sif_ctrl
   import sif_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_mode,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire sif_status_type status,
   output sif_cmd_type         cmd
);

   sif_state_type state_ff;
   sif_state_type state_in;
   logic          rsp_valid_ff;
   logic          out_free;
   logic          advance;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = (state_ff == ST_DECIDE) && (!status.needs_out || out_free);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && (req_mode == MODE_PROBE)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (advance) begin
               state_in = status.last ? ST_CLEAR : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd.load_we  = (state_ff == ST_IDLE) && req_valid && (req_mode == MODE_LOAD);
      cmd.probe_rd = (state_ff == ST_IDLE) && req_valid && (req_mode == MODE_PROBE);
      cmd.rep_we   = advance && status.hit;
      cmd.out_load = advance && status.needs_out;
      cmd.clr_step = (state_ff == ST_CLEAR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // a waiting result is never overwritten
   `ASSERT_CLK(a_no_overwrite, clock, reset, cmd.out_load |-> out_free)
   // the end of a job always starts the clearing sweep
   `ASSERT_CLK(a_last_clears, clock, reset, (advance && status.last) |=> (state_ff == ST_CLEAR))
   // a probe request moves to the decide state in the following cycle
   `ASSERT_CLK(a_probe_decide, clock, reset, cmd.probe_rd |=> (state_ff == ST_DECIDE))

endmodule

`default_nettype wire

// ----- hw/rtl/sif_dpath.sv -----
// membership stores, probe registers and result register
`default_nettype none
`include "assert_macros.svh"

module sif_dpath
   import sif_pkg::*;
#(
   parameter int DOMAIN_SIZE = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [ELEMENT_W-1:0] req_element,
   input  wire logic                 req_last,
   input  wire sif_cmd_type          cmd,
   output sif_status_type            status,
   output logic [ELEMENT_W-1:0]      rsp_value,
   output logic                      rsp_member,
   output logic                      rsp_done_res
);

   localparam int AddrW = (DOMAIN_SIZE > 1) ? $clog2(DOMAIN_SIZE) : 1;
   localparam logic [AddrW-1:0] LastAddr = AddrW'(DOMAIN_SIZE - 1);

   logic                 present_ff  [DOMAIN_SIZE];
   logic                 reported_ff [DOMAIN_SIZE];
   logic                 present_rd_ff;
   logic                 reported_rd_ff;
   logic [ELEMENT_W-1:0] elem_ff;
   logic                 last_ff;
   logic                 in_range_ff;
   logic [AddrW-1:0]     clr_cnt_ff;
   logic [ELEMENT_W-1:0] value_ff;
   logic                 member_ff;
   logic                 done_ff;

   logic                 req_in_range;
   logic                 pres_we;
   logic [AddrW-1:0]     pres_addr;
   logic                 pres_wdata;
   logic                 rep_we;
   logic [AddrW-1:0]     rep_addr;
   logic                 rep_wdata;
   logic                 hit;

   assign req_in_range = 32'(req_element) < 32'(DOMAIN_SIZE);
   assign hit          = in_range_ff && present_rd_ff && !reported_rd_ff;

   // sweep writes take the port while clearing, requests otherwise
   always_comb begin
      pres_we    = cmd.clr_step || (cmd.load_we && req_in_range);
      pres_addr  = cmd.clr_step ? clr_cnt_ff : AddrW'(req_element);
      pres_wdata = !cmd.clr_step;
      rep_we     = cmd.clr_step || cmd.rep_we;
      rep_addr   = cmd.clr_step ? clr_cnt_ff : AddrW'(elem_ff);
      rep_wdata  = !cmd.clr_step;
   end

   always_ff @(posedge clock) begin
      if (pres_we) begin
         present_ff[pres_addr] <= pres_wdata;
      end
      if (rep_we) begin
         reported_ff[rep_addr] <= rep_wdata;
      end
      if (cmd.probe_rd) begin
         present_rd_ff  <= present_ff[AddrW'(req_element)];
         reported_rd_ff <= reported_ff[AddrW'(req_element)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.probe_rd) begin
         elem_ff     <= req_element;
         last_ff     <= req_last;
         in_range_ff <= req_in_range;
      end
      if (cmd.out_load) begin
         value_ff  <= hit ? elem_ff : '0;
         member_ff <= hit;
         done_ff   <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= (clr_cnt_ff == LastAddr) ? '0 : clr_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      status.hit       = hit;
      status.last      = last_ff;
      status.needs_out = hit || last_ff;
      status.clr_done  = (clr_cnt_ff == LastAddr);
   end

   assign rsp_value    = value_ff;
   assign rsp_member   = member_ff;
   assign rsp_done_res = done_ff;

   // the sweep counter rests at zero outside a clearing pass
   `ASSERT_CLK(a_cnt_rest, clock, reset, (clr_cnt_ff != '0) |-> cmd.clr_step)
   // a probe read is never followed directly by a load
   `ASSERT_CLK(a_rd_then_decide, clock, reset, cmd.probe_rd |=> !cmd.load_we)
   // reported bits are only set outside the sweep
   `ASSERT_CLK(a_rep_no_sweep, clock, reset, cmd.rep_we |-> (hit && !cmd.clr_step))

endmodule

`default_nettype wire

// ----- sim/set_intersection_filter_tb.sv -----
// testbench for the set intersection filter: directed table, random jobs, self-checking
`timescale 1ns / 1ps

module set_intersection_filter_tb
   import sif_pkg::*;
();

   localparam int DOMAIN        = 1024;
   localparam int NUM_DIRECTED  = 18;
   localparam int RANDOM_ITEMS  = 1400;
   localparam int QUIET_TAIL    = 200;
   localparam int STALL_LIMIT   = 8000;
   localparam int SETTLE_CYCLES = 1100;

   typedef enum logic {
      CHK_MODEL,
      CHK_FIXED
   } check_kind_type;

   typedef struct packed {
      logic [ELEMENT_W-1:0] value;
      logic                 member;
      logic                 done_res;
   } match_type;

   typedef struct packed {
      logic                 mode;
      logic [ELEMENT_W-1:0] element;
      logic                 last;
      check_kind_type       chk;
      logic [ELEMENT_W-1:0] value;
      logic                 member;
      logic                 done_res;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_mode;
   logic [ELEMENT_W-1:0] req_element;
   logic                 req_last;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ELEMENT_W-1:0] rsp_value;
   logic                 rsp_member;
   logic                 rsp_done_res;

   bit        present_map  [DOMAIN];
   bit        reported_map [DOMAIN];
   match_type pending_matches [$];
   int        error_count  = 0;
   int        items_sent   = 0;
   int        stall_left   = 0;
   int        quiet_cycles = 0;
   bit        idle_on      = 1'b1;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      // probe right after reset, nothing loaded yet
      '{MODE_PROBE, 10'd5,    1'b1, CHK_FIXED, 10'd0,    1'b0, 1'b1},
      '{MODE_LOAD,  10'd0,    1'b0, CHK_MODEL, 10'd0,    1'b0, 1'b0},
      '{MODE_LOAD,  10'd1023, 1'b0, CHK_MODEL, 10'd0,    1'b0, 1'b0},
      '{MODE_LOAD,  10'd1023, 1'b0, CHK_MODEL, 10'd0,    1'b0, 1'b0},
      // last flag on a load does not end the job
      '{MODE_LOAD,  10'd512,  1'b1, CHK_MODEL, 10'd0,    1'b0, 1'b0},
      '{MODE_LOAD,  10'd341,  1'b0, CHK_MODEL, 10'd0,    1'b0, 1'b0},
      '{MODE_LOAD,  10'd682,  1'b0, CHK_MODEL, 10'd0,    1'b0, 1'b0},
      '{MODE_PROBE, 10'd1023, 1'b0, CHK_FIXED, 10'd1023, 1'b1, 1'b0},
      '{MODE_PROBE, 10'd1023, 1'b0, CHK_MODEL, 10'd0,    1'b0, 1'b0},
      '{MODE_PROBE, 10'd7,    1'b0, CHK_MODEL, 10'd0,    1'b0, 1'b0},
      '{MODE_PROBE, 10'd0,    1'b0, CHK_FIXED, 10'd0,    1'b1, 1'b0},
      '{MODE_PROBE, 10'd341,  1'b0, CHK_MODEL, 10'd0,    1'b0, 1'b0},
      '{MODE_PROBE, 10'd512,  1'b1, CHK_FIXED, 10'd512,  1'b1, 1'b1},
      // stores must be empty after the last probe
      '{MODE_PROBE, 10'd0,    1'b1, CHK_FIXED, 10'd0,    1'b0, 1'b1},
      '{MODE_LOAD,  10'd682,  1'b0, CHK_MODEL, 10'd0,    1'b0, 1'b0},
      '{MODE_PROBE, 10'd682,  1'b0, CHK_MODEL, 10'd0,    1'b0, 1'b0},
      '{MODE_PROBE, 10'd682,  1'b1, CHK_FIXED, 10'd0,    1'b0, 1'b1},
      '{MODE_PROBE, 10'd682,  1'b1, CHK_FIXED, 10'd0,    1'b0, 1'b1}
   };

   set_intersection_filter #(
      .DOMAIN_SIZE(DOMAIN)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_element (req_element),
      .req_last    (req_last),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_value   (rsp_value),
      .rsp_member  (rsp_member),
      .rsp_done_res(rsp_done_res)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected result of one request, updates the membership stores
   function automatic bit intersect_step(input logic mode, input logic [ELEMENT_W-1:0] elem,
                                         input logic last, output match_type res);
      bit hit;
      hit = 1'b0;
      res = '0;
      if (mode == MODE_LOAD) begin
         if (int'(elem) < DOMAIN) present_map[elem] = 1'b1;
         return 1'b0;
      end
      if (int'(elem) < DOMAIN && present_map[elem] && !reported_map[elem]) begin
         reported_map[elem] = 1'b1;
         hit = 1'b1;
      end
      if (!hit && !last) return 1'b0;
      res.value    = hit ? elem : '0;
      res.member   = hit;
      res.done_res = last;
      if (last) begin
         present_map  = '{default: 1'b0};
         reported_map = '{default: 1'b0};
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      error_count++;
   endtask

   task automatic issue_request(input logic mode, input logic [ELEMENT_W-1:0] elem,
                                input logic last, input check_kind_type chk,
                                input match_type fixed);
      match_type predicted;
      bit        has_result;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_element <= elem;
      req_last    <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      has_result = intersect_step(mode, elem, last, predicted);
      if (chk == CHK_FIXED) pending_matches = {pending_matches, fixed};
      else if (has_result) pending_matches = {pending_matches, predicted};
   endtask

   // one job: loads from a value window, then probes (with stray loads) ending in a last probe
   task automatic run_job();
      int                   span;
      int                   base;
      int                   n_load;
      int                   n_probe;
      logic [ELEMENT_W-1:0] el;
      span    = ($urandom_range(0, 4) == 0) ? DOMAIN : $urandom_range(2, 24);
      base    = $urandom_range(0, DOMAIN - span);
      n_load  = $urandom_range(0, 10);
      n_probe = $urandom_range(1, 12);
      for (int i = 0; i < n_load; i++) begin
         el = ELEMENT_W'(base + $urandom_range(0, span - 1));
         issue_request(MODE_LOAD, el, $urandom_range(0, 9) == 0, CHK_MODEL, '0);
      end
      for (int i = 0; i < n_probe; i++) begin
         // stray load in the middle of the probes
         if ($urandom_range(0, 9) == 0) begin
            el = ELEMENT_W'(base + $urandom_range(0, span - 1));
            issue_request(MODE_LOAD, el, 1'b0, CHK_MODEL, '0);
         end
         el = ELEMENT_W'(base + $urandom_range(0, span - 1));
         issue_request(MODE_PROBE, el, i == n_probe - 1, CHK_MODEL, '0);
      end
   endtask

   always @(posedge clock) begin : rsp_side
      match_type expected;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_matches.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               expected = pending_matches.pop_front();
               if (rsp_value !== expected.value)
                  report_mismatch($sformatf("value got %0d want %0d",
                                            rsp_value, expected.value));
               if (rsp_member !== expected.member)
                  report_mismatch($sformatf("member got %0b want %0b",
                                            rsp_member, expected.member));
               if (rsp_done_res !== expected.done_res)
                  report_mismatch($sformatf("done_res got %0b want %0b",
                                            rsp_done_res, expected.done_res));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // no handshake for too long means the block is hung
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_mode    = MODE_LOAD;
      req_element = '0;
      req_last    = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].mode, directed_rows[i].element, directed_rows[i].last,
                       directed_rows[i].chk,
                       '{directed_rows[i].value, directed_rows[i].member,
                         directed_rows[i].done_res});
      end

      // hold off until every result is back
      req_valid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);

      while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            req_valid <= 1'b0;
            while (pending_matches.size() != 0) @(posedge clock);
         end
         idle_on = (items_sent < NUM_DIRECTED + RANDOM_ITEMS - QUIET_TAIL) &&
                   ($urandom_range(0, 3) != 0);
         run_job();
      end

      req_valid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
